@@ hdl/hfd_pkg.sv @@
// Shared types and constants for the hex-float to binary64 converter.
package hfd_pkg;

	localparam int FRAC_W = 56;
	localparam int LZC_W = 6;
	localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
	localparam logic [6:0] EXP_DOT = 7'h2E;
	localparam logic [6:0] EXP_UNDER = 7'h5F;
	localparam logic [6:0] EXP_A = 7'h41;
	localparam logic [6:0] EXP_Z = 7'h5A;
	// Binary64 exponent for leading one at fraction bit p: p + 4*(ex-64) - 56 + 1023.
	localparam logic [10:0] EXP_OFFSET = 11'd711;

	typedef struct packed {
		logic             sign;
		logic [6:0]       ex7;
		logic [FRAC_W-1:0] frac;
		logic             missing;
		logic             zero;
	} s1_t;

	typedef struct packed {
		logic             sign;
		logic [10:0]      bexp;
		logic [FRAC_W-1:0] norm;
		logic             missing;
		logic             zero;
	} s2_t;

endpackage

@@ hdl/hfd_norm.sv @@
// Normalization stage: leading-zero count and left shift of the fraction.
module hfd_norm (
	input  hfd_pkg::s1_t in_s,
	output hfd_pkg::s2_t out_s
);

	logic [hfd_pkg::LZC_W-1:0] lz;
	logic [hfd_pkg::LZC_W-1:0] p;

	always_comb begin
		lz = '0;
		for (int i = 0; i < hfd_pkg::FRAC_W; i++) begin
			if (in_s.frac[i]) begin
				lz = hfd_pkg::LZC_W'(hfd_pkg::FRAC_W - 1 - i);
			end
		end
		p = hfd_pkg::LZC_W'(hfd_pkg::FRAC_W - 1) - lz;
		out_s.sign = in_s.sign;
		out_s.missing = in_s.missing;
		out_s.zero = in_s.zero;
		out_s.norm = in_s.frac << lz;
		out_s.bexp = hfd_pkg::EXP_OFFSET + {4'd0, in_s.ex7} * 11'd4 + {5'd0, p};
	end

endmodule

@@ hdl/hfd_round.sv @@
// Rounding stage: 56 to 53 bits, nearest even, and final packing.
module hfd_round (
	input  hfd_pkg::s2_t in_s,
	output logic [63:0] bits,
	output logic        missing
);

	logic [53:0] m;
	logic        g;
	logic        rs;
	logic        up;
	logic [10:0] e;

	always_comb begin
		g = in_s.norm[2];
		rs = |in_s.norm[1:0];
		up = g && (rs || in_s.norm[3]);
		m = {1'b0, in_s.norm[55:3]} + {53'd0, up};
		e = in_s.bexp;
		if (m[53]) begin
			e = e + 11'd1;
		end
		missing = in_s.missing;
		if (in_s.missing) begin
			bits = hfd_pkg::QNAN_BITS;
		end else if (in_s.zero) begin
			bits = {in_s.sign, 63'd0};
		end else begin
			// On carry-out the mantissa field is all zero either way.
			bits = {in_s.sign, e, m[53] ? 52'd0 : m[51:0]};
		end
	end

endmodule

@@ hdl/ibm_hex_float_to_ieee_double.sv @@
// Top level of the hex-float to binary64 converter pipeline.
// Usage: present a 64-bit hex-float word on ibm_word with in_valid; it is
// taken when in_valid and in_ready are both high. The converted binary64
// pattern appears on ieee_bits with is_missing and out_valid, and is taken
// when out_valid and out_ready are both high.
// Pipeline: three register stages (decode, normalize, round and pack).
// A result passes through the decode, normalize and round-and-pack
// registers in order. Throughput is one transaction per cycle while the
// receiver does not stall, set by the fully pipelined datapath.
// When the receiver stalls, the pipeline advances only into empty stages;
// in_ready is low only when all stages hold data and the output is held.
// No transaction is lost or repeated.
// Reset clears all stage valid bits; the pipeline starts empty.
module ibm_hex_float_to_ieee_double (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] ibm_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] ieee_bits,
	output logic        is_missing
);

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;
	hfd_pkg::s1_t d_s1, dec;
	hfd_pkg::s2_t d_s2, nrm;
	logic [63:0] bits_c;
	logic        miss_c;
	logic [6:0]  ex;

	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		ex = ibm_word[62:56];
		dec.sign = ibm_word[63];
		dec.ex7 = ex;
		dec.frac = ibm_word[55:0];
		dec.zero = ~|ibm_word[55:0];
		dec.missing = dec.zero && (ex == hfd_pkg::EXP_DOT || ex == hfd_pkg::EXP_UNDER
			|| (ex >= hfd_pkg::EXP_A && ex <= hfd_pkg::EXP_Z));
	end

	hfd_norm u_norm (.in_s(d_s1), .out_s(nrm));
	hfd_round u_round (.in_s(d_s2), .bits(bits_c), .missing(miss_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) d_s1 <= dec;
		if (adv2) d_s2 <= nrm;
		if (adv3) begin
			ieee_bits <= bits_c;
			is_missing <= miss_c;
		end
	end

	assign out_valid = v_s3;

endmodule

@@ hdl/hfd_checker.sv @@
// Port-level checker for the converter, bound to the top level.
module hfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] ieee_bits,
	input logic        is_missing
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ieee_bits))
		else $error("output changed while stalled");

	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_missing |-> ieee_bits == hfd_pkg::QNAN_BITS)
		else $error("missing code without quiet NaN");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("latency exceeded");

endmodule

bind ibm_hex_float_to_ieee_double hfd_checker u_hfd_checker (.*);
